// ===== rtl/hcbd_pkg.sv =====
// Shared codes and small byte classifiers for the chunked body decoder.
// No dependencies; the top level refers to it by scoped names.
package hcbd_pkg;

    // Decoder phase codes. Codes 6 and 7 behave as PH_DONE.
    localparam logic [2:0] PH_LEAD   = 3'd0;
    localparam logic [2:0] PH_DIGITS = 3'd1;
    localparam logic [2:0] PH_EXT    = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_SKIP   = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // End-of-stream status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_MARKER  = 2'd1;
    localparam logic [1:0] ST_TRUNCATED  = 2'd2;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_X_LO = 8'h78;
    localparam logic [7:0] CH_X_UP = 8'h58;

    localparam logic [2:0] MARKER_LEN = 3'd5;

    // One output entry of the result queue.
    typedef struct packed {
        logic       kind;
        logic [7:0] payload;
        logic [1:0] status;
        logic       last;
    } result_t;

    // Byte of the end marker "0 CR LF CR LF" at a given position.
    function automatic logic [7:0] marker_byte(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CH_ZERO;
            3'd1:    c = CH_CR;
            3'd2:    c = CH_LF;
            3'd3:    c = CH_CR;
            3'd4:    c = CH_LF;
            default: c = CH_ZERO;
        endcase
        return c;
    endfunction

    // Returns {is_hex, value}.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(c - 8'h61 + 8'd10)};
        end else if (c inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(c - 8'h41 + 8'd10)};
        end
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    endfunction

endpackage

// ===== rtl/http_chunked_body_decoder_core.sv =====
// Chunked HTTP body decoder: byte-wide input stream in, payload bytes and an
// end-of-stream status item out. Depends on hcbd_pkg for codes and byte classifiers.
//
// Usage:
//   The s_ channel carries the raw chunked body, one byte per word, with
//   s_tlast on the final byte of the body. The m_ channel carries results:
//   m_tuser = 0 marks a decoded payload byte, m_tuser = 1 the status item
//   that follows the final input byte (0 ok, 1 end marker 0 CR LF CR LF never
//   seen, 2 body ended while payload bytes were still owed). m_tlast marks the
//   last result caused by one input word. Size lines, trailers and bytes
//   after the terminating chunk produce no result.
//   Each accepted word is held in an input register; when the queue has room
//   for its results, a short combinational step updates the decoder state and
//   writes zero, one or two results into a two-entry output queue. A result
//   shows on m_ from the queue's head register until the receiver takes it.
//   One word is accepted per cycle as long as the queue has room for the
//   results of the held word. A final byte that also carries payload writes
//   two results at once; the size line after it gives none, so a receiver
//   that is always ready never holds back the input. When the receiver
//   stalls, s_tready drops once the held word no longer fits; nothing is lost.
//   A synchronous active-low reset empties the input register and the queue
//   and returns the decoder to the start of a size line. The final byte also
//   returns the decoder to that state after its status item.
module http_chunked_body_decoder_core #(
    parameter int SIZE_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [7:0] body_byte
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: [7:0] payload_byte, [9:8] end_status, [15:10] zero
    output logic [15:0] m_tdata,
    // m_tuser: [0] item_kind
    output logic        m_tuser,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready
);

    localparam logic [SIZE_BITS-1:0] SIZE_MAX = {SIZE_BITS{1'b1}};

    typedef struct packed {
        logic [2:0]           phase;
        logic [SIZE_BITS-1:0] size;
        logic                 digits;
        logic [1:0]           prefix;
    } line_t;

    // Input register.
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // Decoder state.
    line_t       line_reg, line_next;
    logic        cr_pending_reg, cr_pending_next;
    logic [1:0]  trailer_reg, trailer_next;
    logic [2:0]  match_reg, match_next;
    logic        found_reg, found_next;

    // Output queue, entry 0 is the head.
    hcbd_pkg::result_t q0_reg, q1_reg, q0_next, q1_next;
    logic [1:0]  cnt_reg, cnt_next;

    hcbd_pkg::result_t res0, res1;
    logic [1:0]  n_res;
    logic [1:0]  room;
    logic        pop;
    logic        step_go;

    // Takes one hex digit into the size, saturating at the top.
    function automatic line_t take_digit(input line_t s, input logic [3:0] d);
        line_t r;
        r = s;
        r.prefix = (s.prefix == 2'd0 && d == 4'd0) ? 2'd1 : 2'd3;
        r.digits = 1'b1;
        if (s.size[SIZE_BITS-1 -: 4] != 4'd0) begin
            r.size = SIZE_MAX;
        end else begin
            r.size = {s.size[SIZE_BITS-5:0], d};
        end
        return r;
    endfunction

    // One ordinary byte of a size line.
    function automatic line_t line_byte(input line_t s, input logic [7:0] c);
        line_t      r;
        logic [4:0] hv;
        r  = s;
        hv = hcbd_pkg::hex_digit(c);
        if (s.phase == hcbd_pkg::PH_LEAD) begin
            if (!hcbd_pkg::is_space(c)) begin
                if (hv[4]) begin
                    r       = take_digit(s, hv[3:0]);
                    r.phase = hcbd_pkg::PH_DIGITS;
                end else begin
                    r.phase = hcbd_pkg::PH_EXT;
                end
            end
        end else if (s.phase == hcbd_pkg::PH_DIGITS) begin
            if ((c == hcbd_pkg::CH_X_LO || c == hcbd_pkg::CH_X_UP) && s.prefix == 2'd1) begin
                r.prefix = 2'd2;
                r.digits = 1'b0;
            end else if (hv[4]) begin
                r = take_digit(s, hv[3:0]);
            end else begin
                r.phase = hcbd_pkg::PH_EXT;
            end
        end
        return r;
    endfunction

    // Decoder step for the held word.
    always_comb begin
        logic [2:0] m;
        logic       pay;
        logic [1:0] st;
        line_next       = line_reg;
        cr_pending_next = cr_pending_reg;
        trailer_next    = trailer_reg;
        match_next      = match_reg;
        found_next      = found_reg;
        pay             = 1'b0;
        st              = hcbd_pkg::ST_OK;
        m               = match_reg;

        // End marker search runs over the whole stream until the marker is found.
        if (!found_reg) begin
            if (m > 3'd4) begin
                m = 3'd0;
            end
            if (in_byte_reg == hcbd_pkg::marker_byte(m)) begin
                m = m + 3'd1;
            end else begin
                m = (in_byte_reg == hcbd_pkg::CH_ZERO) ? 3'd1 : 3'd0;
            end
            if (m >= hcbd_pkg::MARKER_LEN) begin
                found_next = 1'b1;
                m          = 3'd0;
            end
            match_next = m;
        end

        case (line_reg.phase)
            hcbd_pkg::PH_LEAD, hcbd_pkg::PH_DIGITS, hcbd_pkg::PH_EXT: begin
                if (cr_pending_reg) begin
                    cr_pending_next = 1'b0;
                    if (in_byte_reg == hcbd_pkg::CH_LF) begin
                        // Line end: a missing or zero size ends decoding.
                        if (!line_reg.digits || line_reg.size == '0) begin
                            line_next.phase = hcbd_pkg::PH_DONE;
                            line_next.size  = '0;
                        end else begin
                            line_next.phase = hcbd_pkg::PH_DATA;
                        end
                        line_next.digits = 1'b0;
                        line_next.prefix = 2'd0;
                    end else begin
                        // The held CR was a lone CR: it counts as a line byte.
                        line_next = line_byte(line_reg, hcbd_pkg::CH_CR);
                        if (in_byte_reg == hcbd_pkg::CH_CR) begin
                            cr_pending_next = 1'b1;
                        end else begin
                            line_next = line_byte(line_next, in_byte_reg);
                        end
                    end
                end else if (in_byte_reg == hcbd_pkg::CH_CR) begin
                    cr_pending_next = 1'b1;
                end else begin
                    line_next = line_byte(line_reg, in_byte_reg);
                end
            end
            hcbd_pkg::PH_DATA: begin
                pay = 1'b1;
                if (line_reg.size <= SIZE_BITS'(1)) begin
                    line_next.size  = '0;
                    line_next.phase = hcbd_pkg::PH_SKIP;
                    trailer_next    = 2'd2;
                end else begin
                    line_next.size = line_reg.size - SIZE_BITS'(1);
                end
            end
            hcbd_pkg::PH_SKIP: begin
                if (trailer_reg <= 2'd1) begin
                    trailer_next    = 2'd0;
                    line_next.phase = hcbd_pkg::PH_LEAD;
                end else begin
                    trailer_next = trailer_reg - 2'd1;
                end
            end
            default: begin
            end
        endcase

        if (!found_next) begin
            st = hcbd_pkg::ST_NO_MARKER;
        end else if (line_next.phase == hcbd_pkg::PH_DATA) begin
            st = hcbd_pkg::ST_TRUNCATED;
        end

        // Results of this word, in order.
        res0 = '{kind: hcbd_pkg::KIND_PAYLOAD, payload: in_byte_reg,
                 status: hcbd_pkg::ST_OK, last: !in_last_reg};
        res1 = '{kind: hcbd_pkg::KIND_STATUS, payload: 8'd0, status: st, last: 1'b1};
        if (!pay) begin
            res0 = res1;
        end
        n_res = {1'b0, pay} + {1'b0, in_last_reg};

        // The final byte returns the decoder to its reset state.
        if (in_last_reg) begin
            line_next       = '{phase: hcbd_pkg::PH_LEAD, size: '0, digits: 1'b0,
                                prefix: 2'd0};
            cr_pending_next = 1'b0;
            trailer_next    = 2'd0;
            match_next      = 3'd0;
            found_next      = 1'b0;
        end
    end

    assign pop      = m_tvalid && m_tready;
    assign room     = 2'd2 - cnt_reg + {1'b0, pop};
    assign step_go  = in_valid_reg && (n_res <= room);
    assign s_tready = !in_valid_reg || step_go;

    // Output queue: pop from the head, then append this word's results.
    always_comb begin
        logic [1:0] cnt_a;
        hcbd_pkg::result_t q0_a;
        cnt_a   = cnt_reg - {1'b0, pop};
        q0_a    = pop ? q1_reg : q0_reg;
        q0_next = q0_a;
        q1_next = q1_reg;
        cnt_next = cnt_a;
        if (step_go && n_res != 2'd0) begin
            if (cnt_a == 2'd0) begin
                q0_next = res0;
                q1_next = res1;
            end else begin
                q1_next = res0;
            end
            cnt_next = cnt_a + n_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            cnt_reg        <= 2'd0;
            line_reg       <= '{phase: hcbd_pkg::PH_LEAD, size: '0, digits: 1'b0,
                                prefix: 2'd0};
            cr_pending_reg <= 1'b0;
            trailer_reg    <= 2'd0;
            match_reg      <= 3'd0;
            found_reg      <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (step_go) begin
                in_valid_reg <= 1'b0;
            end
            if (step_go) begin
                line_reg       <= line_next;
                cr_pending_reg <= cr_pending_next;
                trailer_reg    <= trailer_next;
                match_reg      <= match_next;
                found_reg      <= found_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tuser  = q0_reg.kind;
    assign m_tlast  = q0_reg.last;
    assign m_tdata  = {6'd0, q0_reg.status, q0_reg.payload};

    // The queue never holds more than two results.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'd2)
        else $error("result queue overflow");

    // Payload phase always has bytes left to pass.
    a_data_size: assert property (@(posedge aclk) disable iff (!aresetn)
        line_reg.phase == hcbd_pkg::PH_DATA |-> line_reg.size != '0)
        else $error("payload phase with zero size");

    // A status item always closes the run of its input word.
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == hcbd_pkg::KIND_STATUS |-> m_tlast)
        else $error("status item not marked last");

    // After the final byte the decoder is back at the start of a size line.
    a_final_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        step_go && in_last_reg |=> line_reg.phase == hcbd_pkg::PH_LEAD && !found_reg
            && match_reg == 3'd0)
        else $error("decoder not reset after final byte");

    // Marker progress stays inside the marker.
    a_match_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        match_reg < hcbd_pkg::MARKER_LEN)
        else $error("marker match out of range");

endmodule
